>>> design/eased_colour_fade_interpolator_assert.svh
// Assertion macros shared by the fade interpolator RTL.
`ifndef EASED_COLOUR_FADE_INTERPOLATOR_ASSERT_SVH
`define EASED_COLOUR_FADE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ECFI_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ECFI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ecfi_pkg.sv
package ecfi_pkg;

   localparam int unsigned CHANNELS = 4;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned TAG_W    = 16;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned Q_W      = 17;   // unsigned Q1.16, holds 1.0

   localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
   localparam logic [Q_W-1:0] Q_HALF = 17'h08000;

   localparam logic [TIME_W-1:0] DURATION_RESET = 16'd300;
   localparam logic              ENABLE_RESET   = 1'b0;

   // CSR register indexes
   localparam logic CSR_DURATION = 1'b0;
   localparam logic CSR_ENABLE   = 1'b1;

   typedef enum logic [1:0] {
      MODE_PASS_FROM,
      MODE_PASS_TO,
      MODE_BLEND
   } mode_type;

   typedef struct packed {
      logic [TAG_W-1:0]                 tag;
      logic [CHANNELS-1:0][CHAN_W-1:0]  from_ch;
      logic [CHANNELS-1:0][CHAN_W-1:0]  to_ch;
      mode_type                         mode;
   } item_type;

endpackage

>>> design/eased_colour_fade_interpolator.sv
// The pipe holds 15 register stages from the accepted req word to rsp_tvalid.
// Throughput: one word per cycle; the whole pipe holds while rsp is stalled.
// Capture, then eight divide stages at two quotient bits each, then the ease
// operand, square, cube, ease, blend magnitude and output register stages.
// Reset clears all valid bits and sets duration to 300 ms, fade disabled.
`include "eased_colour_fade_interpolator_assert.svh"

module eased_colour_fade_interpolator (
   input  logic        clock,
   input  logic        reset,
   // tdata: pixel_index[15:0], elapsed_ms[31:16], from_red[39:32],
   //        from_green[47:40], from_blue[55:48], from_white[63:56],
   //        to_red[71:64], to_green[79:72], to_blue[87:80], to_white[95:88]
   input  logic [95:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: pixel_tag[15:0], out_red[23:16], out_green[31:24],
   //        out_blue[39:32], out_white[47:40]
   output logic [47:0] rsp_tdata,
   // tuser: fade_done[0]
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned DIV_STAGES = 8;
   localparam int unsigned S_DIV_END  = DIV_STAGES;
   localparam int unsigned S_X        = S_DIV_END + 1;
   localparam int unsigned S_SQ       = S_X + 1;
   localparam int unsigned S_CUBE     = S_SQ + 1;
   localparam int unsigned S_EASE     = S_CUBE + 1;
   localparam int unsigned S_MAG      = S_EASE + 1;
   localparam int unsigned S_OUT      = S_MAG + 1;
   localparam int unsigned STAGES     = S_OUT + 1;

   localparam int unsigned TW = ecfi_pkg::TIME_W;
   localparam int unsigned QW = ecfi_pkg::Q_W;
   localparam int unsigned CW = ecfi_pkg::CHAN_W;
   localparam int unsigned NC = ecfi_pkg::CHANNELS;

   // ---------------- configuration ----------------
   logic [TW-1:0] duration_ff;
   logic          enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= ecfi_pkg::DURATION_RESET;
         enable_ff   <= ecfi_pkg::ENABLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ecfi_pkg::CSR_DURATION: duration_ff <= csr_wdata;
            ecfi_pkg::CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic                 advance;
   logic [STAGES-1:0]    valid_ff;
   ecfi_pkg::item_type   item_ff [STAGES];

   assign advance    = !valid_ff[S_OUT] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[S_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_tvalid};
      end
   end

   // ---------------- stage 0: capture and classify ----------------
   logic [TW-1:0]      elapsed_in;
   ecfi_pkg::item_type item_in;
   logic [TW-1:0]      rem_ff [DIV_STAGES+1];
   logic [TW-1:0]      quo_ff [DIV_STAGES+1];

   always_comb begin
      elapsed_in    = req_tdata[31:16];
      item_in.tag   = req_tdata[15:0];
      item_in.from_ch = req_tdata[63:32];
      item_in.to_ch   = req_tdata[95:64];
      if (!enable_ff) begin
         item_in.mode = ecfi_pkg::MODE_PASS_FROM;
      end else if (duration_ff == '0 || elapsed_in >= duration_ff) begin
         item_in.mode = ecfi_pkg::MODE_PASS_TO;
      end else begin
         item_in.mode = ecfi_pkg::MODE_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff[0] <= item_in;
         rem_ff[0]  <= elapsed_in;
         quo_ff[0]  <= '0;
      end
   end

   // items ride along unchanged through the later stages
   for (genvar s = 1; s < STAGES; s++) begin : g_item
      always_ff @(posedge clock) begin
         if (advance) begin
            item_ff[s] <= item_ff[s-1];
         end
      end
   end

   // ---------------- progress divide: (elapsed << 16) / duration ----------------
   // Restoring divide; the remainder stays below the divisor on blend words.
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [TW:0]   try_a;
      logic [TW:0]   try_b;
      logic          ge_a;
      logic          ge_b;
      logic [TW-1:0] rem_a;
      logic [TW-1:0] rem_in;
      logic [TW-1:0] quo_in;

      always_comb begin
         try_a  = {rem_ff[k-1], 1'b0};
         ge_a   = try_a >= {1'b0, duration_ff};
         rem_a  = ge_a ? TW'(try_a - {1'b0, duration_ff}) : try_a[TW-1:0];
         try_b  = {rem_a, 1'b0};
         ge_b   = try_b >= {1'b0, duration_ff};
         rem_in = ge_b ? TW'(try_b - {1'b0, duration_ff}) : try_b[TW-1:0];
         quo_in = {quo_ff[k-1][TW-3:0], ge_a, ge_b};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   // ---------------- ease curve ----------------
   // Lower half cubes p, upper half cubes q = 2 - 2p; both share the multipliers.
   logic [TW-1:0]  prog;
   logic [QW-1:0]  x_in;
   logic [QW-1:0]  x_ff;
   logic           lower_x_ff;
   logic [2*QW-1:0] sq_prod_in;
   logic [QW-1:0]  sq_ff;
   logic [QW-1:0]  x_sq_ff;
   logic           lower_sq_ff;
   logic [2*QW-1:0] cube_prod_in;
   logic [QW-1:0]  cube_ff;
   logic           lower_cube_ff;
   logic [QW-1:0]  ease_in;
   logic [QW-1:0]  ease_ff;

   assign prog         = quo_ff[DIV_STAGES];
   assign x_in         = prog[TW-1] ? QW'((2 * ecfi_pkg::Q_ONE) - {prog, 1'b0})
                                    : {1'b0, prog};
   assign sq_prod_in   = (2*QW)'(x_ff) * (2*QW)'(x_ff);
   assign cube_prod_in = (2*QW)'(sq_ff) * (2*QW)'(x_sq_ff);
   assign ease_in      = lower_cube_ff ? {cube_ff[QW-3:0], 2'b00}
                                       : QW'(ecfi_pkg::Q_ONE - {1'b0, cube_ff[QW-1:1]});

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff          <= x_in;
         lower_x_ff    <= !prog[TW-1];
         sq_ff         <= sq_prod_in[QW+15:16];
         x_sq_ff       <= x_ff;
         lower_sq_ff   <= lower_x_ff;
         cube_ff       <= cube_prod_in[QW+15:16];
         lower_cube_ff <= lower_sq_ff;
         ease_ff       <= ease_in;
      end
   end

   // ---------------- blend ----------------
   logic [NC-1:0][CW-1:0] mag_ff;
   logic [NC-1:0][CW-1:0] mag_in;
   logic [47:0]           rsp_tdata_ff;
   logic [47:0]           rsp_tdata_in;
   logic                  rsp_tuser_ff;
   logic                  rsp_tuser_in;

   always_comb begin
      logic [CW-1:0]    diff;
      logic [CW+QW-1:0] prod;
      for (int c = 0; c < NC; c++) begin
         if (item_ff[S_EASE].to_ch[c] >= item_ff[S_EASE].from_ch[c]) begin
            diff = item_ff[S_EASE].to_ch[c] - item_ff[S_EASE].from_ch[c];
         end else begin
            diff = item_ff[S_EASE].from_ch[c] - item_ff[S_EASE].to_ch[c];
         end
         prod      = (CW+QW)'(diff) * (CW+QW)'(ease_ff);
         mag_in[c] = prod[CW+15:16];
      end
   end

   always_comb begin
      logic [NC-1:0][CW-1:0] colour;
      for (int c = 0; c < NC; c++) begin
         if (item_ff[S_MAG].to_ch[c] >= item_ff[S_MAG].from_ch[c]) begin
            colour[c] = item_ff[S_MAG].from_ch[c] + mag_ff[c];
         end else begin
            colour[c] = item_ff[S_MAG].from_ch[c] - mag_ff[c];
         end
      end
      unique case (item_ff[S_MAG].mode)
         ecfi_pkg::MODE_PASS_FROM: colour = item_ff[S_MAG].from_ch;
         ecfi_pkg::MODE_PASS_TO:   colour = item_ff[S_MAG].to_ch;
         default: ;
      endcase
      rsp_tdata_in = {colour, item_ff[S_MAG].tag};
      rsp_tuser_in = item_ff[S_MAG].mode == ecfi_pkg::MODE_PASS_TO;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff       <= mag_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // ---------------- assertions ----------------
   `ECFI_ASSERT_NEXT(a_stall_freezes_pipe, !advance, $stable(valid_ff),
      "pipeline moved while output stalled")
   `ECFI_ASSERT_IMPL(a_ease_in_range, valid_ff[S_EASE], ease_ff <= ecfi_pkg::Q_ONE,
      "eased value above one")
   `ECFI_ASSERT_IMPL(a_lower_half_ease, valid_ff[S_CUBE] && lower_cube_ff,
      ease_in < ecfi_pkg::Q_HALF, "lower-half ease reached one half")

endmodule
